FILE: sv/tea_pkg.sv
package tea_pkg;

    localparam int NUM_SENSORS = 8;
    localparam int SENSOR_AW   = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    localparam int ID_W    = 3;
    localparam int TEMP_W  = 16;
    localparam int TIME_W  = 32;
    localparam int HOLD_W  = 20;
    localparam int IVL_W   = 16;
    localparam int COUNT_W = 8;
    localparam int BOUND_W = IVL_W + COUNT_W + 1;

    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_CUTOFF    = 2'd0;
    localparam logic [1:0] REG_INTERVAL  = 2'd1;
    localparam logic [1:0] REG_COUNT_MAX = 2'd2;

    localparam logic signed [TEMP_W-1:0] CUTOFF_RESET    = -16'sd5000;
    localparam logic [IVL_W-1:0]         INTERVAL_RESET  = 16'd3600;
    localparam logic [COUNT_W-1:0]       COUNT_MAX_RESET = 8'd3;

    typedef struct packed {
        logic [ID_W-1:0]          sensor_index;
        logic signed [TEMP_W-1:0] temperature;
        logic [TIME_W-1:0]        now_secs;
        logic signed [TEMP_W-1:0] cold_limit;
        logic signed [TEMP_W-1:0] hot_limit;
        logic [HOLD_W-1:0]        cold_hold_secs;
        logic [HOLD_W-1:0]        hot_hold_secs;
    } sample_t;

    typedef struct packed {
        logic [ID_W-1:0]    sensor_id_out;
        logic               alarm_fired;
        logic               alarm_active;
        logic               is_disconnected;
        logic               connection_changed;
        logic [TIME_W-1:0]  elapsed_secs;
        logic [COUNT_W-1:0] alarms_raised;
    } result_t;

    typedef struct packed {
        logic [ID_W-1:0]   sensor_index;
        logic              id_valid;
        logic              below_cutoff;
        logic              in_band;
        logic [HOLD_W-1:0] hold_secs;
        logic [TIME_W-1:0] now_secs;
    } cmd_t;

    typedef struct packed {
        logic [IVL_W-1:0]   repeat_gap;
        logic [COUNT_W-1:0] repeat_limit;
    } back_cfg_t;

endpackage

FILE: sv/tea_front.sv
module tea_front (
    input  tea_pkg::sample_t                  sample,
    input  logic signed [tea_pkg::TEMP_W-1:0] cutoff_temperature,
    output tea_pkg::cmd_t                     cmd
);

    logic at_or_below_cold;
    logic at_or_above_hot;

    always_comb
    begin
        at_or_below_cold = (sample.temperature <= sample.cold_limit);
        at_or_above_hot  = (sample.temperature >= sample.hot_limit);

        cmd.sensor_index = sample.sensor_index;
        cmd.id_valid     = (32'(sample.sensor_index) < tea_pkg::NUM_SENSORS);
        cmd.below_cutoff = (sample.temperature < cutoff_temperature);
        cmd.in_band      = !at_or_below_cold && !at_or_above_hot;
        cmd.hold_secs    = at_or_below_cold ? sample.cold_hold_secs : sample.hot_hold_secs;
        cmd.now_secs     = sample.now_secs;
    end

endmodule

FILE: sv/tea_queue.sv
module tea_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tea_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output tea_pkg::cmd_t pop_data
);

    tea_pkg::cmd_t                 entry_reg [tea_pkg::QUEUE_DEPTH];
    logic [tea_pkg::QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [tea_pkg::QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [tea_pkg::QUEUE_CW-1:0]  count_reg, count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full      = (count_reg == tea_pkg::QUEUE_CW'(tea_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == tea_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == tea_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/tea_back.sv
module tea_back (
    input  logic               clk,
    input  logic               rst_n,
    input  tea_pkg::back_cfg_t cfg,
    input  logic               cmd_valid,
    input  tea_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               result_valid,
    input  logic               result_stall,
    output tea_pkg::result_t   result
);

    logic [tea_pkg::NUM_SENSORS-1:0] disc_reg;
    logic [tea_pkg::NUM_SENSORS-1:0] alarm_reg;
    logic [tea_pkg::NUM_SENSORS-1:0] started_reg;
    logic [tea_pkg::TIME_W-1:0]      start_reg [tea_pkg::NUM_SENSORS];
    logic [tea_pkg::COUNT_W-1:0]     count_reg [tea_pkg::NUM_SENSORS];

    logic                            res_valid_reg;
    tea_pkg::result_t                res_reg;

    logic [tea_pkg::SENSOR_AW-1:0]   idx;
    logic                            disc_cur;
    logic                            alarm_cur;
    logic                            started_cur;
    logic [tea_pkg::TIME_W-1:0]      start_cur;
    logic [tea_pkg::COUNT_W-1:0]     count_cur;

    logic                            disc_next;
    logic                            alarm_next;
    logic                            started_next;
    logic                            start_load;
    logic [tea_pkg::COUNT_W-1:0]     count_next;
    logic [tea_pkg::TIME_W-1:0]      elapsed;
    logic [tea_pkg::BOUND_W-1:0]     bound;
    logic                            fired;
    logic                            changed;
    tea_pkg::result_t                res_next;

    assign cmd_pop      = cmd_valid && (!res_valid_reg || !result_stall);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign idx         = tea_pkg::SENSOR_AW'(cmd.sensor_index);
    assign disc_cur    = disc_reg[idx];
    assign alarm_cur   = alarm_reg[idx];
    assign started_cur = started_reg[idx];
    assign start_cur   = start_reg[idx];
    assign count_cur   = count_reg[idx];

    always_comb
    begin
        disc_next    = disc_cur;
        alarm_next   = alarm_cur;
        started_next = started_cur;
        start_load   = 1'b0;
        count_next   = count_cur;
        elapsed      = '0;
        fired        = 1'b0;
        changed      = 1'b0;
        bound        = tea_pkg::BOUND_W'(cfg.repeat_gap) * tea_pkg::BOUND_W'(count_cur)
                     + tea_pkg::BOUND_W'(cmd.hold_secs);

        if (cmd.below_cutoff)
        begin
            if (!disc_cur)
            begin
                disc_next    = 1'b1;
                changed      = 1'b1;
                alarm_next   = 1'b0;
                started_next = 1'b0;
                count_next   = '0;
            end
        end
        else
        begin
            disc_next = 1'b0;
            changed   = disc_cur;
            if (cmd.in_band)
            begin
                alarm_next   = 1'b0;
                started_next = 1'b0;
                count_next   = '0;
            end
            else
            begin
                if (!started_cur)
                begin
                    started_next = 1'b1;
                    start_load   = 1'b1;
                end
                else
                begin
                    elapsed = cmd.now_secs - start_cur;
                end
                if (alarm_cur)
                begin
                    fired = (elapsed > tea_pkg::TIME_W'(bound))
                         && (count_cur <= cfg.repeat_limit);
                end
                else
                begin
                    fired = (elapsed > tea_pkg::TIME_W'(cmd.hold_secs));
                end
                if (fired)
                begin
                    alarm_next = 1'b1;
                    if (count_cur != tea_pkg::COUNT_SAT)
                    begin
                        count_next = count_cur + 1'b1;
                    end
                end
            end
        end

        res_next = '0;
        res_next.sensor_id_out = cmd.sensor_index;
        if (cmd.id_valid)
        begin
            res_next.alarm_fired        = fired;
            res_next.alarm_active       = alarm_next;
            res_next.is_disconnected    = disc_next;
            res_next.connection_changed = changed;
            res_next.elapsed_secs       = elapsed;
            res_next.alarms_raised      = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            disc_reg      <= '0;
            alarm_reg     <= '0;
            started_reg   <= '0;
            for (int i = 0; i < tea_pkg::NUM_SENSORS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd_pop)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            if (cmd_pop && cmd.id_valid)
            begin
                disc_reg[idx]    <= disc_next;
                alarm_reg[idx]   <= alarm_next;
                started_reg[idx] <= started_next;
                count_reg[idx]   <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            res_reg <= res_next;
        end
        if (cmd_pop && cmd.id_valid && start_load)
        begin
            start_reg[idx] <= cmd.now_secs;
        end
    end

endmodule

FILE: sv/temperature_excursion_alarm_core.sv
// Temperature excursion alarm core.
// Sample channel: one request per sensor sample (sample_valid / sample_stall,
// payload sample). The core keeps disconnect, alarm, timer and count state for
// each sensor and answers every request with exactly one result on the result
// channel (result_valid / result_stall, payload result), in request order.
// An accepted request is written into the queue, then popped into the result
// register, which raises result_valid. Throughput: one request per cycle while
// result_stall is low; a two-entry queue sits between the classifying front
// end and the state update, a read-modify-write of the per-sensor registers,
// so samples of the same sensor may follow each other in consecutive cycles.
// While a valid result is stalled the result register holds; the queue takes
// requests until both entries are full, then sample_stall rises.
// Reset: all sensor state clears to connected, no alarm, no excursion, count
// zero; cutoff temperature = -5000, repeat gap = 3600 s, repeat limit = 3.
// Registers at APB byte addresses 0, 4 and 8; write them only while no
// request is in flight.
module temperature_excursion_alarm_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  tea_pkg::sample_t             sample,
    output logic                         result_valid,
    input  logic                         result_stall,
    output tea_pkg::result_t             result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tea_pkg::PADDR_W-1:0]  paddr,
    input  logic [tea_pkg::PDATA_W-1:0]  pwdata,
    output logic [tea_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    logic signed [tea_pkg::TEMP_W-1:0] cutoff_reg;
    logic [tea_pkg::IVL_W-1:0]         interval_reg;
    logic [tea_pkg::COUNT_W-1:0]       count_max_reg;
    logic [1:0]                        reg_sel;
    logic                              cfg_write;

    tea_pkg::cmd_t                     front_cmd;
    tea_pkg::cmd_t                     queue_cmd;
    logic                              queue_full;
    logic                              queue_valid;
    logic                              queue_pop;
    tea_pkg::back_cfg_t                back_cfg;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_sel)
            tea_pkg::REG_CUTOFF:    prdata = tea_pkg::PDATA_W'($unsigned(cutoff_reg));
            tea_pkg::REG_INTERVAL:  prdata = tea_pkg::PDATA_W'(interval_reg);
            tea_pkg::REG_COUNT_MAX: prdata = tea_pkg::PDATA_W'(count_max_reg);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg    <= tea_pkg::CUTOFF_RESET;
            interval_reg  <= tea_pkg::INTERVAL_RESET;
            count_max_reg <= tea_pkg::COUNT_MAX_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                tea_pkg::REG_CUTOFF:    cutoff_reg    <= pwdata[tea_pkg::TEMP_W-1:0];
                tea_pkg::REG_INTERVAL:  interval_reg  <= pwdata[tea_pkg::IVL_W-1:0];
                tea_pkg::REG_COUNT_MAX: count_max_reg <= pwdata[tea_pkg::COUNT_W-1:0];
                default:                ;
            endcase
        end
    end

    assign sample_stall          = queue_full;
    assign back_cfg.repeat_gap   = interval_reg;
    assign back_cfg.repeat_limit = count_max_reg;

    tea_front u_front (
        .sample             (sample),
        .cutoff_temperature (cutoff_reg),
        .cmd                (front_cmd)
    );

    tea_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (sample_valid),
        .push_data (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_valid (queue_valid),
        .pop_data  (queue_cmd)
    );

    tea_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (back_cfg),
        .cmd_valid    (queue_valid),
        .cmd          (queue_cmd),
        .cmd_pop      (queue_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

FILE: sv/tea_checker.sv
module tea_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         result_valid,
    input  logic                         result_stall,
    input  tea_pkg::result_t             result
);

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_disconnected_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_disconnected |->
            !result.alarm_active && !result.alarm_fired
            && result.elapsed_secs == '0 && result.alarms_raised == '0)
        else $error("disconnected sensor reports alarm state");

    a_fired_sets_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.alarm_fired |->
            result.alarm_active && result.alarms_raised != '0)
        else $error("fired alarm without active flag or count");

    a_count_needs_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.alarm_active |-> result.alarms_raised == '0)
        else $error("alarm count without active alarm");

endmodule

bind temperature_excursion_alarm_core tea_checker u_tea_checker (.*);
